### rtl/hslrgb_pkg.sv
// Shared types and constants for the HSL to RGB converter.
package hslrgb_pkg;

	typedef struct packed {
		logic signed [15:0] hue_deg;
		logic [7:0]         saturation;
		logic [7:0]         lightness;
		logic [7:0]         alpha_in;
	} hsl_pix_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha_out;
	} rgb_pix_t;

	typedef enum logic [2:0] {
		SEC_RY,
		SEC_YG,
		SEC_GC,
		SEC_CB,
		SEC_BM,
		SEC_MR
	} hue_sector_t;

	localparam int HUE_TURN        = 360;
	localparam int HUE_SECTOR      = 60;
	localparam int HUE_BIAS        = 33120;
	localparam int HUE_RECIP       = 186413;
	localparam int HUE_RECIP_SHIFT = 26;
	localparam int HUE_U_W         = 17;
	localparam int HUE_PROD_W      = 35;
	localparam int HUE_Q_W         = 8;
	localparam int HUE_R_W         = 10;
	localparam int HUE_H_W         = 9;
	localparam int HUE_HM_W        = 7;
	localparam int HUE_HM_DEPTH    = 120;
	localparam int BYTE_MAX        = 255;

endpackage

### rtl/hsl_to_rgb_converter_top.sv
// Top level of the HSL to RGB converter: four-stage pipeline.
//
//  channel  direction  handshake            payload
//  hsl      in         hsl_valid/hsl_ready  hslrgb_pkg::hsl_pix_t
//  rgb      out        rgb_valid/rgb_ready  hslrgb_pkg::rgb_pix_t
//
// One pixel enters per clock unless a stall on rgb_ready has filled every stage.
// Latency is set by the four register stages: hue reduction, chroma multiply,
// secondary-component multiply, and byte scaling with the output register.
// Reset clears every stage's valid bit; payload registers are not reset.
// Each stage holds its item while the next is full, so a stall on rgb_ready
// backs up one stage at a time and bubbles are filled.
module hsl_to_rgb_converter_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hsl_valid,
	output logic                 hsl_ready,
	input  hslrgb_pkg::hsl_pix_t hsl,
	output logic                 rgb_valid,
	input  logic                 rgb_ready,
	output hslrgb_pkg::rgb_pix_t rgb
);

	logic                            f_valid;
	logic                            f_ready;
	hslrgb_pkg::hue_sector_t         f_sector;
	logic [hslrgb_pkg::HUE_HM_W-1:0] f_hm;
	logic [FRAC_BITS:0]              f_chroma;
	logic [FRAC_BITS:0]              f_light;
	logic [7:0]                      f_alpha;

	logic                            m_valid;
	logic                            m_ready;
	hslrgb_pkg::hue_sector_t         m_sector;
	logic [FRAC_BITS:0]              m_chroma;
	logic [FRAC_BITS:0]              m_second;
	logic [FRAC_BITS:0]              m_offset;
	logic [7:0]                      m_alpha;

	hslrgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (hsl_valid),
		.up_ready  (hsl_ready),
		.up        (hsl),
		.dn_valid  (f_valid),
		.dn_ready  (f_ready),
		.dn_sector (f_sector),
		.dn_hm     (f_hm),
		.dn_chroma (f_chroma),
		.dn_light  (f_light),
		.dn_alpha  (f_alpha)
	);

	hslrgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (f_valid),
		.up_ready  (f_ready),
		.up_sector (f_sector),
		.up_hm     (f_hm),
		.up_chroma (f_chroma),
		.up_light  (f_light),
		.up_alpha  (f_alpha),
		.dn_valid  (m_valid),
		.dn_ready  (m_ready),
		.dn_sector (m_sector),
		.dn_chroma (m_chroma),
		.dn_second (m_second),
		.dn_offset (m_offset),
		.dn_alpha  (m_alpha)
	);

	hslrgb_out #(.FRAC_BITS(FRAC_BITS)) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (m_valid),
		.up_ready  (m_ready),
		.up_sector (m_sector),
		.up_chroma (m_chroma),
		.up_second (m_second),
		.up_offset (m_offset),
		.up_alpha  (m_alpha),
		.dn_valid  (rgb_valid),
		.dn_ready  (rgb_ready),
		.dn        (rgb)
	);

	a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!hsl_ready |-> rgb_valid && !rgb_ready)
		else $error("input refused while the output side is free");

	a_out_follows_in: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_ready && !m_valid |=> !rgb_valid)
		else $error("result appeared with no item behind it");

endmodule

### rtl/hslrgb_front.sv
// Hue reduction, fraction lookup and chroma product: two pipeline stages.
module hslrgb_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              up_valid,
	output logic                              up_ready,
	input  hslrgb_pkg::hsl_pix_t              up,
	output logic                              dn_valid,
	input  logic                              dn_ready,
	output hslrgb_pkg::hue_sector_t           dn_sector,
	output logic [hslrgb_pkg::HUE_HM_W-1:0]   dn_hm,
	output logic [FRAC_BITS:0]                dn_chroma,
	output logic [FRAC_BITS:0]                dn_light,
	output logic [7:0]                        dn_alpha
);

	localparam int UW = FRAC_BITS + 1;
	localparam logic [UW:0] ONE_W = (UW + 1)'(1) << FRAC_BITS;

	typedef logic [255:0][UW-1:0] frac_tab_t;

	function automatic frac_tab_t build_frac_tab();
		frac_tab_t t;
		longint    v;
		for (int i = 0; i < 256; i++) begin
			v = (longint'(i) << FRAC_BITS) + 254;
			t[i] = UW'(v / 255);
		end
		return t;
	endfunction

	localparam frac_tab_t FRAC_TAB = build_frac_tab();

	logic [hslrgb_pkg::HUE_U_W-1:0]    hue_u;
	logic [hslrgb_pkg::HUE_PROD_W-1:0] hue_prod;

	logic                              valid_s1;
	logic                              rdy_s1;
	logic [hslrgb_pkg::HUE_U_W-1:0]    u_s1;
	logic [hslrgb_pkg::HUE_Q_W-1:0]    q_s1;
	logic [UW-1:0]                     lq_s1;
	logic [UW-1:0]                     sq_s1;
	logic [7:0]                        alpha_s1;

	logic [hslrgb_pkg::HUE_R_W-1:0]    rem;
	logic [hslrgb_pkg::HUE_H_W-1:0]    h;
	hslrgb_pkg::hue_sector_t           sector;
	logic [hslrgb_pkg::HUE_H_W-1:0]    hm_base;
	logic [hslrgb_pkg::HUE_HM_W-1:0]   hm;
	logic [UW:0]                       two_l;
	logic [UW:0]                       l_dev;
	logic [UW-1:0]                     oma;
	logic [2*UW-1:0]                   c_prod;

	logic                              valid_s2;
	logic                              rdy_s2;
	hslrgb_pkg::hue_sector_t           sector_s2;
	logic [hslrgb_pkg::HUE_HM_W-1:0]   hm_s2;
	logic [UW-1:0]                     c_s2;
	logic [UW-1:0]                     lq_s2;
	logic [7:0]                        alpha_s2;

	// bias by a whole number of turns so the hue is positive, then estimate the quotient
	assign hue_u = hslrgb_pkg::HUE_U_W'({up.hue_deg[15], up.hue_deg})
		+ hslrgb_pkg::HUE_U_W'(hslrgb_pkg::HUE_BIAS);
	assign hue_prod = hslrgb_pkg::HUE_PROD_W'(hue_u)
		* hslrgb_pkg::HUE_PROD_W'(hslrgb_pkg::HUE_RECIP);

	assign rdy_s2   = !valid_s2 || dn_ready;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= up_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && rdy_s1) begin
			u_s1     <= hue_u;
			q_s1     <= hue_prod[hslrgb_pkg::HUE_RECIP_SHIFT +: hslrgb_pkg::HUE_Q_W];
			lq_s1    <= FRAC_TAB[up.lightness];
			sq_s1    <= FRAC_TAB[up.saturation];
			alpha_s1 <= up.alpha_in;
		end
	end

	// the quotient estimate is exact or one low: correct with one subtract
	always_comb begin
		rem = hslrgb_pkg::HUE_R_W'(u_s1 - hslrgb_pkg::HUE_U_W'(
			hslrgb_pkg::HUE_U_W'(q_s1) * hslrgb_pkg::HUE_U_W'(hslrgb_pkg::HUE_TURN)));
		if (rem >= hslrgb_pkg::HUE_R_W'(hslrgb_pkg::HUE_TURN)) begin
			h = hslrgb_pkg::HUE_H_W'(rem - hslrgb_pkg::HUE_R_W'(hslrgb_pkg::HUE_TURN));
		end else begin
			h = hslrgb_pkg::HUE_H_W'(rem);
		end

		priority if (h < hslrgb_pkg::HUE_H_W'(hslrgb_pkg::HUE_SECTOR)) begin
			sector = hslrgb_pkg::SEC_RY;
		end else if (h < hslrgb_pkg::HUE_H_W'(2 * hslrgb_pkg::HUE_SECTOR)) begin
			sector = hslrgb_pkg::SEC_YG;
		end else if (h < hslrgb_pkg::HUE_H_W'(3 * hslrgb_pkg::HUE_SECTOR)) begin
			sector = hslrgb_pkg::SEC_GC;
		end else if (h < hslrgb_pkg::HUE_H_W'(4 * hslrgb_pkg::HUE_SECTOR)) begin
			sector = hslrgb_pkg::SEC_CB;
		end else if (h < hslrgb_pkg::HUE_H_W'(5 * hslrgb_pkg::HUE_SECTOR)) begin
			sector = hslrgb_pkg::SEC_BM;
		end else begin
			sector = hslrgb_pkg::SEC_MR;
		end

		unique case (sector)
			hslrgb_pkg::SEC_RY, hslrgb_pkg::SEC_YG: begin
				hm_base = '0;
			end
			hslrgb_pkg::SEC_GC, hslrgb_pkg::SEC_CB: begin
				hm_base = hslrgb_pkg::HUE_H_W'(2 * hslrgb_pkg::HUE_SECTOR);
			end
			default: begin
				hm_base = hslrgb_pkg::HUE_H_W'(4 * hslrgb_pkg::HUE_SECTOR);
			end
		endcase
		hm = hslrgb_pkg::HUE_HM_W'(h - hm_base);

		two_l = {lq_s1, 1'b0};
		if (two_l >= ONE_W) begin
			l_dev = two_l - ONE_W;
		end else begin
			l_dev = ONE_W - two_l;
		end
		oma    = UW'(ONE_W - l_dev);
		c_prod = (2 * UW)'(oma) * (2 * UW)'(sq_s1);
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && rdy_s2) begin
			sector_s2 <= sector;
			hm_s2     <= hm;
			c_s2      <= c_prod[FRAC_BITS +: UW];
			lq_s2     <= lq_s1;
			alpha_s2  <= alpha_s1;
		end
	end

	assign dn_valid  = valid_s2;
	assign dn_sector = sector_s2;
	assign dn_hm     = hm_s2;
	assign dn_chroma = c_s2;
	assign dn_light  = lq_s2;
	assign dn_alpha  = alpha_s2;

	a_hm_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> hm_s2 < hslrgb_pkg::HUE_HM_W'(hslrgb_pkg::HUE_HM_DEPTH))
		else $error("hue offset within sector pair out of range");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !dn_ready |=> valid_s2 && $stable(c_s2) && $stable(hm_s2))
		else $error("stage 2 lost its item while stalled");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !rdy_s2 |=> valid_s1 && $stable(q_s1))
		else $error("stage 1 lost its item while stalled");

endmodule

### rtl/hslrgb_mix.sv
// Secondary component X and lightness offset m: one pipeline stage.
module hslrgb_mix #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              up_valid,
	output logic                              up_ready,
	input  hslrgb_pkg::hue_sector_t           up_sector,
	input  logic [hslrgb_pkg::HUE_HM_W-1:0]   up_hm,
	input  logic [FRAC_BITS:0]                up_chroma,
	input  logic [FRAC_BITS:0]                up_light,
	input  logic [7:0]                        up_alpha,
	output logic                              dn_valid,
	input  logic                              dn_ready,
	output hslrgb_pkg::hue_sector_t           dn_sector,
	output logic [FRAC_BITS:0]                dn_chroma,
	output logic [FRAC_BITS:0]                dn_second,
	output logic [FRAC_BITS:0]                dn_offset,
	output logic [7:0]                        dn_alpha
);

	localparam int UW = FRAC_BITS + 1;
	localparam longint ONE = longint'(1) << FRAC_BITS;

	typedef logic [hslrgb_pkg::HUE_HM_DEPTH-1:0][UW-1:0] slope_tab_t;

	// weight 1 - |hm/60 - 1| for each offset within a sector pair
	function automatic slope_tab_t build_slope_tab();
		slope_tab_t t;
		longint     d;
		for (int i = 0; i < hslrgb_pkg::HUE_HM_DEPTH; i++) begin
			d = ((longint'(i) << FRAC_BITS) / hslrgb_pkg::HUE_SECTOR) - ONE;
			if (d < 0) begin
				d = -d;
			end
			t[i] = UW'(ONE - d);
		end
		return t;
	endfunction

	localparam slope_tab_t SLOPE_TAB = build_slope_tab();

	logic [UW-1:0]           weight;
	logic [2*UW-1:0]         x_prod;
	logic                    valid_s3;
	logic                    rdy_s3;
	hslrgb_pkg::hue_sector_t sector_s3;
	logic [UW-1:0]           c_s3;
	logic [UW-1:0]           x_s3;
	logic [UW-1:0]           m_s3;
	logic [7:0]              alpha_s3;

	assign weight   = SLOPE_TAB[up_hm];
	assign x_prod   = (2 * UW)'(up_chroma) * (2 * UW)'(weight);
	assign rdy_s3   = !valid_s3 || dn_ready;
	assign up_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && rdy_s3) begin
			sector_s3 <= up_sector;
			c_s3      <= up_chroma;
			x_s3      <= x_prod[FRAC_BITS +: UW];
			m_s3      <= up_light - {1'b0, up_chroma[UW-1:1]};
			alpha_s3  <= up_alpha;
		end
	end

	assign dn_valid  = valid_s3;
	assign dn_sector = sector_s3;
	assign dn_chroma = c_s3;
	assign dn_second = x_s3;
	assign dn_offset = m_s3;
	assign dn_alpha  = alpha_s3;

	a_x_le_c: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> x_s3 <= c_s3)
		else $error("secondary component exceeds chroma");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !dn_ready |=> valid_s3 && $stable(x_s3) && $stable(m_s3))
		else $error("stage 3 lost its item while stalled");

endmodule

### rtl/hslrgb_out.sv
// Channel routing, scaling to bytes and clamping: output register stage.
module hslrgb_out #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    up_valid,
	output logic                    up_ready,
	input  hslrgb_pkg::hue_sector_t up_sector,
	input  logic [FRAC_BITS:0]      up_chroma,
	input  logic [FRAC_BITS:0]      up_second,
	input  logic [FRAC_BITS:0]      up_offset,
	input  logic [7:0]              up_alpha,
	output logic                    dn_valid,
	input  logic                    dn_ready,
	output hslrgb_pkg::rgb_pix_t    dn
);

	localparam int UW = FRAC_BITS + 1;
	localparam int SW = UW + 9;

	logic [UW-1:0]        r_c;
	logic [UW-1:0]        g_c;
	logic [UW-1:0]        b_c;
	logic [7:0]           r_b;
	logic [7:0]           g_b;
	logic [7:0]           b_b;
	logic                 valid_s4;
	logic                 rdy_s4;
	hslrgb_pkg::rgb_pix_t pix_s4;

	function automatic logic [7:0] to_byte(input logic [UW-1:0] chan, input logic [UW-1:0] m);
		logic [UW:0]   v;
		logic [SW-1:0] scaled;
		logic [9:0]    raw;
		v      = {1'b0, chan} + {1'b0, m};
		scaled = (SW'(v) << 8) - SW'(v);
		raw    = scaled[FRAC_BITS +: 10];
		if (raw > 10'(hslrgb_pkg::BYTE_MAX)) begin
			return 8'(hslrgb_pkg::BYTE_MAX);
		end
		return raw[7:0];
	endfunction

	always_comb begin
		unique case (up_sector)
			hslrgb_pkg::SEC_RY: begin
				r_c = up_chroma; g_c = up_second; b_c = '0;
			end
			hslrgb_pkg::SEC_YG: begin
				r_c = up_second; g_c = up_chroma; b_c = '0;
			end
			hslrgb_pkg::SEC_GC: begin
				r_c = '0; g_c = up_chroma; b_c = up_second;
			end
			hslrgb_pkg::SEC_CB: begin
				r_c = '0; g_c = up_second; b_c = up_chroma;
			end
			hslrgb_pkg::SEC_BM: begin
				r_c = up_second; g_c = '0; b_c = up_chroma;
			end
			default: begin
				r_c = up_chroma; g_c = '0; b_c = up_second;
			end
		endcase
		r_b = to_byte(r_c, up_offset);
		g_b = to_byte(g_c, up_offset);
		b_b = to_byte(b_c, up_offset);
	end

	assign rdy_s4   = !valid_s4 || dn_ready;
	assign up_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy_s4) begin
			valid_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && rdy_s4) begin
			pix_s4.red       <= r_b;
			pix_s4.green     <= g_b;
			pix_s4.blue      <= b_b;
			pix_s4.alpha_out <= up_alpha;
		end
	end

	assign dn_valid = valid_s4;
	assign dn       = pix_s4;

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		up_valid && rdy_s4 && up_chroma == '0 |=>
		pix_s4.red == pix_s4.green && pix_s4.green == pix_s4.blue)
		else $error("zero chroma gave unequal channels");

endmodule

### sim/tb_hsl_to_rgb_converter_top.sv
// Self-checking testbench for the HSL to RGB converter with a bit-exact colour predictor.
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter_top;

	localparam int FRAC_BITS   = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PIX  = 750;
	localparam int QUIET_TAIL  = 100;
	localparam int DRAIN_AT    = 300;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_LEN    = 64;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 hsl_valid = 1'b0;
	logic                 hsl_ready;
	hslrgb_pkg::hsl_pix_t hsl       = '0;
	logic                 rgb_valid;
	logic                 rgb_ready = 1'b0;
	hslrgb_pkg::rgb_pix_t rgb;

	hslrgb_pkg::hsl_pix_t hsl_feed_q[$];
	hslrgb_pkg::rgb_pix_t rgb_due_q[$];
	int       mismatches = 0;
	int       cycles     = 0;
	int       sent       = 0;
	int       received   = 0;
	int       send_gap   = 0;
	int       recv_stall = 0;
	bit       drained    = 1'b0;
	bit       held_long  = 1'b0;

	hsl_to_rgb_converter_top #(
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.hsl_valid(hsl_valid),
		.hsl_ready(hsl_ready),
		.hsl      (hsl),
		.rgb_valid(rgb_valid),
		.rgb_ready(rgb_ready),
		.rgb      (rgb)
	);

	always #4 clk = ~clk;

	function automatic logic [7:0] channel_byte(longint chan, longint m);
		longint v;
		v = chan + m;
		if (v <= 0)
			return 8'd0;
		v = (v * hslrgb_pkg::BYTE_MAX) >>> FRAC_BITS;
		if (v > hslrgb_pkg::BYTE_MAX)
			v = hslrgb_pkg::BYTE_MAX;
		return v[7:0];
	endfunction

	function automatic hslrgb_pkg::rgb_pix_t convert_pixel(hslrgb_pkg::hsl_pix_t px);
		longint one;
		longint lq, sq, a, c, hm, d, x, m, rp, gp, bp;
		int h;
		hslrgb_pkg::rgb_pix_t res;
		one = longint'(1) <<< FRAC_BITS;
		h = int'($signed(px.hue_deg)) % hslrgb_pkg::HUE_TURN;
		if (h < 0)
			h += hslrgb_pkg::HUE_TURN;
		lq = (longint'(px.lightness) * one + 254) / hslrgb_pkg::BYTE_MAX;
		sq = (longint'(px.saturation) * one + 254) / hslrgb_pkg::BYTE_MAX;
		a = 2 * lq - one;
		if (a < 0)
			a = -a;
		c = ((one - a) * sq) >>> FRAC_BITS;
		hm = longint'(h % (2 * hslrgb_pkg::HUE_SECTOR));
		d = (hm * one) / hslrgb_pkg::HUE_SECTOR - one;
		if (d < 0)
			d = -d;
		x = (c * (one - d)) >>> FRAC_BITS;
		m = lq - (c >>> 1);
		case (hslrgb_pkg::hue_sector_t'(h / hslrgb_pkg::HUE_SECTOR))
			hslrgb_pkg::SEC_RY: begin rp = c; gp = x; bp = 0; end
			hslrgb_pkg::SEC_YG: begin rp = x; gp = c; bp = 0; end
			hslrgb_pkg::SEC_GC: begin rp = 0; gp = c; bp = x; end
			hslrgb_pkg::SEC_CB: begin rp = 0; gp = x; bp = c; end
			hslrgb_pkg::SEC_BM: begin rp = x; gp = 0; bp = c; end
			default: begin rp = c; gp = 0; bp = x; end
		endcase
		res.red       = channel_byte(rp, m);
		res.green     = channel_byte(gp, m);
		res.blue      = channel_byte(bp, m);
		res.alpha_out = px.alpha_in;
		return res;
	endfunction

	function automatic hslrgb_pkg::hsl_pix_t make_pixel(int hue, int sat, int lig, int alp);
		hslrgb_pkg::hsl_pix_t p;
		p.hue_deg    = hue[15:0];
		p.saturation = sat[7:0];
		p.lightness  = lig[7:0];
		p.alpha_in   = alp[7:0];
		return p;
	endfunction

	task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (act_v !== exp_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			hsl_valid <= 1'b0;
		end else begin
			if (hsl_valid && hsl_ready) begin
				rgb_due_q.push_back(convert_pixel(hsl));
				sent++;
			end
			if (hsl_valid && !hsl_ready) begin
				// hold the offered transfer
			end else if (send_gap > 0) begin
				send_gap--;
				hsl_valid <= 1'b0;
			end else if (!drained && sent >= DRAIN_AT) begin
				hsl_valid <= 1'b0;
				if (rgb_due_q.size() == 0)
					drained = 1'b1;
			end else if (hsl_feed_q.size() != 0) begin
				if (hsl_feed_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(1, 16) - 1;
					hsl_valid <= 1'b0;
				end else begin
					hsl_valid <= 1'b1;
					hsl <= hsl_feed_q.pop_front();
				end
			end else begin
				hsl_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		hslrgb_pkg::rgb_pix_t due;
		if (!arst_n) begin
			rgb_ready <= 1'b0;
		end else begin
			if (rgb_valid && rgb_ready) begin
				received++;
				if (rgb_due_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected transfer, expected none, actual %h", $time, rgb);
				end else begin
					due = rgb_due_q.pop_front();
					check_field("red", due.red, rgb.red);
					check_field("green", due.green, rgb.green);
					check_field("blue", due.blue, rgb.blue);
					check_field("alpha_out", due.alpha_out, rgb.alpha_out);
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				rgb_ready <= 1'b0;
			end else if (!held_long && received >= HOLD_AT) begin
				held_long = 1'b1;
				recv_stall = HOLD_LEN - 1;
				rgb_ready <= 1'b0;
			end else if (hsl_feed_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
				recv_stall = $urandom_range(1, 16) - 1;
				rgb_ready <= 1'b0;
			end else begin
				rgb_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int hue;
		int sat;
		int lig;
		int pick;
		// sector edges, hue wrap and extremes, grey and black/white, clamping corners
		hsl_feed_q.push_back(make_pixel(0, 255, 128, 0));
		hsl_feed_q.push_back(make_pixel(60, 255, 128, 255));
		hsl_feed_q.push_back(make_pixel(120, 255, 128, 1));
		hsl_feed_q.push_back(make_pixel(180, 255, 128, 2));
		hsl_feed_q.push_back(make_pixel(240, 255, 128, 4));
		hsl_feed_q.push_back(make_pixel(300, 255, 128, 8));
		hsl_feed_q.push_back(make_pixel(359, 255, 128, 16));
		hsl_feed_q.push_back(make_pixel(360, 255, 128, 32));
		hsl_feed_q.push_back(make_pixel(-1, 255, 128, 64));
		hsl_feed_q.push_back(make_pixel(-360, 255, 128, 128));
		hsl_feed_q.push_back(make_pixel(-32768, 255, 128, 170));
		hsl_feed_q.push_back(make_pixel(32767, 255, 128, 85));
		hsl_feed_q.push_back(make_pixel(30, 0, 0, 0));
		hsl_feed_q.push_back(make_pixel(200, 0, 255, 255));
		hsl_feed_q.push_back(make_pixel(90, 0, 77, 77));
		hsl_feed_q.push_back(make_pixel(45, 255, 255, 12));
		hsl_feed_q.push_back(make_pixel(45, 255, 0, 240));
		hsl_feed_q.push_back(make_pixel(210, 128, 64, 99));
		hsl_feed_q.push_back(make_pixel(-7000, 200, 200, 3));
		hsl_feed_q.push_back(make_pixel(119, 255, 127, 170));
		hsl_feed_q.push_back(make_pixel(121, 1, 1, 85));
		hsl_feed_q.push_back(make_pixel(719, 255, 254, 200));
		hsl_feed_q.push_back(make_pixel(-721, 17, 240, 15));
		for (int i = 0; i < RANDOM_PIX; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 12)
				hue = int'($urandom_range(0, 1800)) - 720;
			else if (pick < 16)
				hue = int'($urandom_range(0, 65535)) - 32768;
			else
				hue = hslrgb_pkg::HUE_SECTOR * (int'($urandom_range(0, 12)) - 6)
					+ int'($urandom_range(0, 2)) - 1;
			pick = $urandom_range(0, 9);
			sat = (pick == 0) ? 0 : (pick == 1) ? 255 : int'($urandom_range(0, 255));
			pick = $urandom_range(0, 9);
			lig = (pick == 0) ? 0 : (pick == 1) ? 255 : int'($urandom_range(0, 255));
			hsl_feed_q.push_back(make_pixel(hue, sat, lig, int'($urandom_range(0, 255))));
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (hsl_feed_q.size() != 0 || hsl_valid || rgb_due_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
rtl/hslrgb_pkg.sv
rtl/hslrgb_front.sv
rtl/hslrgb_mix.sv
rtl/hslrgb_out.sv
rtl/hsl_to_rgb_converter_top.sv
sim/tb_hsl_to_rgb_converter_top.sv
